### rtl/arp_cache_table_unit_macros.svh
// ----------------------------------------------------------------------------
// arp_cache_table_unit_macros.svh
// Assertion shorthands for the address-resolution cache. The clock is clk
// and the asynchronous active-low reset is arst_n in every user.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_TABLE_UNIT_MACROS_SVH
`define ARP_CACHE_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define ACT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ACT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/act_pkg.sv
// ----------------------------------------------------------------------------
// act_pkg
// Shared types and constants of the address-resolution cache.
// ----------------------------------------------------------------------------
package act_pkg;

	localparam int unsigned IP_W  = 32;
	localparam int unsigned MAC_W = 48;
	localparam int unsigned ENT_W = IP_W + MAC_W;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_ADD    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} act_state_t;

endpackage

### rtl/act_ram.sv
// ----------------------------------------------------------------------------
// act_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module act_ram #(
	parameter int unsigned WIDTH = 80,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/arp_cache_table_unit.sv
// ----------------------------------------------------------------------------
// arp_cache_table_unit - address-resolution cache, round-robin replacement
// Scan: ST_SCAN reads one slot per cycle from the RAM; the scan stops at the
//   first matching slot or the last slot, and ST_DONE fills the output register.
// Throughput: one item at a time; the next beat is taken the cycle after the
//   result moves to the output register.
// Reset: per-slot valid bits and the replacement pointer clear at once; an
//   invalid slot reads as IP 0 / MAC 0, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "arp_cache_table_unit_macros.svh"

module arp_cache_table_unit
	import act_pkg::*;
#(
	parameter int unsigned ENTRIES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             func,
	input  logic [IP_W-1:0]  ip_address,
	input  logic [MAC_W-1:0] mac_address,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             hit,
	output logic [MAC_W-1:0] mac_out
);

	localparam int unsigned IDX_W = $clog2(ENTRIES);

	act_state_t         state_q;
	logic               func_q;
	logic [IP_W-1:0]    ip_q;
	logic [MAC_W-1:0]   mac_q;
	logic [IDX_W:0]     scan_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [ENTRIES-1:0] valid_q;

	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic               ent_vld_s1;

	logic               res_hit_q;
	logic [MAC_W-1:0]   res_mac_q;
	logic               out_vld_q;
	logic               out_hit_q;
	logic [MAC_W-1:0]   out_mac_q;

	logic               in_acc;
	logic               rd_en;
	logic [ENT_W-1:0]   rd_data;
	logic [IP_W-1:0]    ent_ip;
	logic [MAC_W-1:0]   ent_mac;
	logic               match;
	logic               last;
	logic               resolve;
	logic               mem_we;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   ptr_nxt;
	logic               out_free;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign rd_en    = (state_q == ST_SCAN) && (scan_q < (IDX_W+1)'(ENTRIES));

	act_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_addr),
		.wdata ({ip_q, mac_q}),
		.re    (rd_en),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	// never-written slots read as cleared
	assign ent_ip  = ent_vld_s1 ? rd_data[ENT_W-1 -: IP_W] : '0;
	assign ent_mac = ent_vld_s1 ? rd_data[MAC_W-1:0] : '0;
	assign match   = (ent_ip == ip_q);
	assign last    = (cmp_idx_s1 == IDX_W'(ENTRIES - 1));
	assign resolve = (state_q == ST_SCAN) && cmp_vld_s1 && (match || last);

	assign ptr_nxt = (ptr_q == IDX_W'(ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
	assign mem_we  = resolve && (func_q == FUNC_ADD);
	assign wr_addr = match ? cmp_idx_s1 : ptr_nxt;

	assign out_free = !out_vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ptr_q      <= '0;
			valid_q    <= '0;
			cmp_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			if (mem_we) begin
				valid_q[wr_addr] <= 1'b1;
				if (!match) begin
					ptr_q <= ptr_nxt;
				end
			end
			if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (resolve) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= func;
			ip_q   <= ip_address;
			mac_q  <= mac_address;
			scan_q <= '0;
		end else if (rd_en) begin
			scan_q <= scan_q + 1'b1;
		end
		if (rd_en) begin
			cmp_idx_s1 <= scan_q[IDX_W-1:0];
			ent_vld_s1 <= valid_q[scan_q[IDX_W-1:0]];
		end
		if (resolve) begin
			res_hit_q <= match;
			res_mac_q <= (func_q == FUNC_LOOKUP && match) ? ent_mac : '0;
		end
		if (state_q == ST_DONE && out_free) begin
			out_hit_q <= res_hit_q;
			out_mac_q <= res_mac_q;
		end
	end

	assign out_valid = out_vld_q;
	assign hit       = out_hit_q;
	assign mac_out   = out_mac_q;

	`ACT_ASSERT_NEXT(a_accept_scans, in_acc, state_q == ST_SCAN,
		"accepted beat did not start a scan")
	`ACT_ASSERT_NOW(a_write_on_resolve, mem_we, (state_q == ST_SCAN) && cmp_vld_s1,
		"RAM write outside scan resolution")
	`ACT_ASSERT_NEXT(a_replace_moves_ptr, mem_we && !match, ptr_q != $past(ptr_q),
		"replacement did not advance pointer")
	`ACT_ASSERT_NOW(a_mac_needs_hit, out_valid && (mac_out != '0), hit,
		"nonzero MAC returned without hit")

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench of the address-resolution cache
// Drives lookup and add beats through a valid/stall channel with random gaps
// and receiver stalls. A model of the eight-slot table with round-robin
// replacement predicts every response, and the monitor checks them in order.
// ----------------------------------------------------------------------------
module tb_top
	import act_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS      = 8;
	localparam int unsigned POOL_SIZE  = 12;
	localparam int unsigned RAND_ITEMS = 1600;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned HOLD_AT    = 300;
	localparam int unsigned HOLD_LEN   = 150;
	localparam int unsigned DRAIN_CYC  = 20;
	localparam int unsigned MAX_PRINTS = 100;

	typedef struct {
		logic             func;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		int unsigned      gap;
	} arp_req_t;

	typedef struct {
		logic             hit;
		logic [MAC_W-1:0] mac;
	} arp_resp_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             func = FUNC_LOOKUP;
	logic [IP_W-1:0]  ip_address = '0;
	logic [MAC_W-1:0] mac_address = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             hit;
	logic [MAC_W-1:0] mac_out;

	arp_req_t    pending_reqs[$];
	arp_resp_t   expected_resps[$];
	logic [IP_W-1:0]  cache_ip[SLOTS];
	logic [MAC_W-1:0] cache_mac[SLOTS];
	int unsigned victim_ptr;

	int unsigned err_cnt = 0;
	int unsigned total_reqs = 0;
	int unsigned reqs_taken = 0;
	int unsigned resps_seen = 0;
	int unsigned idle_cycles = 0;
	logic        req_took = 1'b0;
	logic        resp_took = 1'b0;
	logic        sender_calm = 1'b0;

	arp_cache_table_unit #(.ENTRIES(SLOTS)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.ip_address  (ip_address),
		.mac_address (mac_address),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.mac_out     (mac_out)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (err_cnt < MAX_PRINTS)
			$display("%0t ns mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	// table model: lowest matching slot wins, pointer advances before a replace
	function automatic arp_resp_t resolve_request(input logic f, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac);
		arp_resp_t   r;
		int unsigned slot;
		bit          found;
		r.hit = 1'b0;
		r.mac = '0;
		found = 1'b0;
		slot = 0;
		for (int unsigned i = 0; i < SLOTS; i++) begin
			if (!found && cache_ip[i] == ip) begin
				found = 1'b1;
				slot = i;
			end
		end
		if (f == FUNC_LOOKUP) begin
			if (found) begin
				r.hit = 1'b1;
				r.mac = cache_mac[slot];
			end
		end else if (found) begin
			cache_mac[slot] = mac;
			r.hit = 1'b1;
		end else begin
			victim_ptr = (victim_ptr + 1) % SLOTS;
			cache_ip[victim_ptr] = ip;
			cache_mac[victim_ptr] = mac;
		end
		return r;
	endfunction

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [MAC_W-1:0] m;
		m[31:0] = $urandom;
		m[47:32] = 16'($urandom_range(0, 16'hFFFF));
		return m;
	endfunction

	task automatic queue_beat(input logic f, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac);
		arp_req_t r;
		r.func = f;
		r.ip = ip;
		r.mac = mac;
		r.gap = sender_calm ? 0 : $urandom_range(0, 9);
		pending_reqs.push_back(r);
		total_reqs++;
	endtask

	// input driver: holds a stalled beat, otherwise waits the item's gap
	arp_req_t    cur_req;
	bit          have_cur = 1'b0;
	int unsigned wait_left = 0;

	always @(negedge clk) begin
		logic nxt_valid;
		nxt_valid = 1'b0;
		if (arst_n && !(in_valid && !req_took)) begin
			if (!have_cur && pending_reqs.size() > 0) begin
				cur_req = pending_reqs.pop_front();
				have_cur = 1'b1;
				wait_left = cur_req.gap;
			end
			if (have_cur) begin
				if (wait_left > 0) begin
					wait_left--;
				end else begin
					func <= cur_req.func;
					ip_address <= cur_req.ip;
					mac_address <= cur_req.mac;
					nxt_valid = 1'b1;
					have_cur = 1'b0;
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// output stall driver, with one long hold-off to back up the input
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	always @(negedge clk) begin
		logic nxt_stall;
		nxt_stall = 1'b0;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				nxt_stall = 1'b1;
			end else if (!hold_done && resps_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				nxt_stall = 1'b1;
			end else begin
				if (resp_took)
					stall_left = ((resps_seen / 128) % 3 == 1) ? 0 : $urandom_range(0, 9);
				if (stall_left > 0) begin
					stall_left--;
					nxt_stall = 1'b1;
				end
			end
			out_stall <= nxt_stall;
		end
	end

	// monitor: check responses, then predict on each accepted request beat
	always @(posedge clk) begin
		arp_resp_t want;
		req_took <= arst_n && in_valid && !in_stall;
		resp_took <= arst_n && out_valid && !out_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				resps_seen++;
				if (expected_resps.size() == 0) begin
					report_mismatch("response beat with nothing pending");
				end else begin
					want = expected_resps.pop_front();
					if (hit !== want.hit)
						report_mismatch($sformatf("hit %0b, want %0b", hit, want.hit));
					if (mac_out !== want.mac)
						report_mismatch($sformatf("mac_out %012h, want %012h",
							mac_out, want.mac));
				end
			end
			if (in_valid && !in_stall) begin
				expected_resps.push_back(resolve_request(func, ip_address, mac_address));
				reqs_taken++;
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [IP_W-1:0] ip_pool[POOL_SIZE];
		logic [IP_W-1:0] ip;
		int unsigned     pick;

		for (int unsigned i = 0; i < SLOTS; i++) begin
			cache_ip[i] = '0;
			cache_mac[i] = '0;
		end
		victim_ptr = 0;

		// cleared slots hold IP 0, mac field ignored on lookup
		queue_beat(FUNC_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF);
		queue_beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0);
		queue_beat(FUNC_ADD, 32'h0, 48'hFFFF_FFFF_FFFF);
		queue_beat(FUNC_LOOKUP, 32'h0, 48'h0);
		// first replacement lands in slot 1
		queue_beat(FUNC_ADD, 32'hFFFF_FFFF, 48'h0);
		queue_beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'hAAAA_AAAA_AAAA);
		queue_beat(FUNC_ADD, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA);
		queue_beat(FUNC_ADD, 32'h5555_5555, 48'h5555_5555_5555);
		queue_beat(FUNC_ADD, 32'hFFFF_FFFF, 48'h1234_5678_9ABC);
		queue_beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0);
		for (int unsigned i = 1; i <= 4; i++)
			queue_beat(FUNC_ADD, i, rand_mac());
		// wraps to slot 0 and evicts the IP 0 entry
		queue_beat(FUNC_ADD, 32'h8000_0000, 48'h8000_0000_0001);
		queue_beat(FUNC_LOOKUP, 32'h0, 48'h0);
		queue_beat(FUNC_LOOKUP, 32'hAAAA_AAAA, 48'h0);
		queue_beat(FUNC_ADD, 32'h1, 48'h0);
		queue_beat(FUNC_LOOKUP, 32'h1, 48'h0);
		queue_beat(FUNC_ADD, 32'hC0A8_0001, 48'h0102_0304_0506);
		queue_beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0);
		queue_beat(FUNC_LOOKUP, 32'h8000_0000, 48'h0);

		// small address pool so hits, updates and evictions all happen often
		ip_pool[0] = '0;
		for (int unsigned i = 1; i < POOL_SIZE; i++)
			ip_pool[i] = $urandom;
		for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
			sender_calm = ((n / 200) % 3 == 2);
			pick = $urandom_range(0, 99);
			ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (pick < 45)
				queue_beat(FUNC_LOOKUP, ip, rand_mac());
			else if (pick < 80)
				queue_beat(FUNC_ADD, ip, rand_mac());
			else if (pick < 90)
				queue_beat(FUNC_LOOKUP, $urandom, rand_mac());
			else
				queue_beat(FUNC_ADD, $urandom, rand_mac());
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (reqs_taken != total_reqs)
			@(negedge clk);
		while (expected_resps.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);

		if (expected_resps.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", expected_resps.size()));
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
